// ----- rtl/core/dtpg_pkg.sv -----
// ----------------------------------------------------------------------------
// dtpg_pkg
// Shared types, constants and helper functions of the test pattern generator.
// ----------------------------------------------------------------------------
package dtpg_pkg;

  localparam int COL_W      = 10;
  localparam int ROW_W      = 10;
  localparam int DIM_W      = 11;
  localparam int PIX_W      = 24;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MAX_DIM    = 1024;
  localparam int BAND_COUNT = 8;
  localparam int BAND_BITS  = $clog2(BAND_COUNT);
  localparam int BAND_H_W   = DIM_W - BAND_BITS;
  localparam int RAMP_BITS  = 8;
  localparam int REM_W      = COL_W + RAMP_BITS;
  localparam int DSH_W      = REM_W + 1;

  localparam logic [7:0]       CH_FULL     = 8'hFF;
  localparam logic [7:0]       CH_GREY     = 8'h77;
  localparam logic [PIX_W-1:0] RGB565_MASK = 24'h00FFDF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_MODE = 3'd0,
    CFG_PIXEL_FORMAT = 3'd1,
    CFG_FRAME_WIDTH  = 3'd2,
    CFG_FRAME_HEIGHT = 3'd3,
    CFG_SOLID_COLOR  = 3'd4
  } cfg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_BARS  = 2'd0,
    MODE_GREY  = 2'd1,
    MODE_SOLID = 2'd2
  } mode_t;

  typedef enum logic {
    FMT_RGB565 = 1'b0,
    FMT_RGB888 = 1'b1
  } fmt_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              fmt;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [PIX_W-1:0]  solid;
  } dtpg_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic                 cov;
    logic [ROW_W-1:0]     row;
    logic [ROW_W-1:0]     brem;
    logic [BAND_BITS-1:0] band;
    logic [REM_W-1:0]     rem255;
    logic [REM_W-1:0]     rem119;
    logic [RAMP_BITS-1:0] q255;
    logic [RAMP_BITS-1:0] q119;
  } dtpg_pipe_t;

  function automatic logic [PIX_W-1:0] band_color(input logic [BAND_BITS-1:0] band);
    logic [PIX_W-1:0] c;
    unique case (band)
      3'd0:    c = 24'hFFFFFF;
      3'd1:    c = 24'h777777;
      3'd2:    c = 24'hFF0000;
      3'd3:    c = 24'h00FF00;
      3'd4:    c = 24'h0000FF;
      3'd5:    c = 24'h00FFFF;
      3'd6:    c = 24'hFF00FF;
      default: c = 24'hFFFF00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ramp_chan(input logic [7:0] base,
                                           input logic [RAMP_BITS-1:0] q255,
                                           input logic [RAMP_BITS-1:0] q119);
    logic [7:0] v;
    if (base == CH_FULL) begin
      v = q255;
    end else if (base == CH_GREY) begin
      v = q119;
    end else begin
      v = 8'd0;
    end
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] pack_color(input logic fmt,
                                                  input logic [PIX_W-1:0] rgb);
    logic [PIX_W-1:0] p;
    if (fmt == FMT_RGB565) begin
      p = {8'd0, rgb[23:19], rgb[15:10], rgb[7:3]};
    end else begin
      p = rgb;
    end
    return p;
  endfunction

endpackage

// ----- rtl/core/dtpg_ifs.sv -----
// ----------------------------------------------------------------------------
// dtpg channel interfaces
// Valid/ready channels for coordinate items, pixel items and register writes.
// ----------------------------------------------------------------------------
interface dtpg_in_if import dtpg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row;

  modport source (output valid, output column, output row, input ready);
  modport sink (input valid, input column, input row, output ready);
endinterface

interface dtpg_out_if import dtpg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             covered;

  modport source (output valid, output pixel_value, output covered, input ready);
  modport sink (input valid, input pixel_value, input covered, output ready);
endinterface

interface dtpg_cfg_if import dtpg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/dtpg_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// dtpg_cfg_regs
// Configuration register file written through the register write channel.
// ----------------------------------------------------------------------------
module dtpg_cfg_regs import dtpg_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  dtpg_cfg_if.sink        cfg_wr,
  output dtpg_cfg_t       cfg
);

  dtpg_cfg_t cfg_r, cfg_nxt;

  assign cfg_wr.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CFG_PATTERN_MODE: cfg_nxt.mode   = cfg_wr.data[MODE_W-1:0];
        CFG_PIXEL_FORMAT: cfg_nxt.fmt    = cfg_wr.data[0];
        CFG_FRAME_WIDTH:  cfg_nxt.width  = cfg_wr.data[DIM_W-1:0];
        CFG_FRAME_HEIGHT: cfg_nxt.height = cfg_wr.data[DIM_W-1:0];
        CFG_SOLID_COLOR:  cfg_nxt.solid  = cfg_wr.data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= MODE_BARS;
      cfg_r.fmt    <= FMT_RGB565;
      cfg_r.width  <= DIM_W'(MAX_DIM);
      cfg_r.height <= DIM_W'(MAX_DIM);
      cfg_r.solid  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/core/dtpg_div_cell.sv -----
// ----------------------------------------------------------------------------
// dtpg_div_cell
// One restoring divider cell: resolves quotient bit BIT of both ramps and,
// in the low cells, one bit of the band index, then hands the item on.
// ----------------------------------------------------------------------------
module dtpg_div_cell import dtpg_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  dtpg_pipe_t          up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output dtpg_pipe_t          dn_data,
  input  logic [DIM_W-1:0]    width,
  input  logic [BAND_H_W-1:0] band_h
);

  localparam int BB = BIT % BAND_BITS;

  logic             valid_r, valid_nxt;
  dtpg_pipe_t       data_r, data_nxt;
  logic [DSH_W-1:0] dsh;
  logic [DIM_W-1:0] bsh;

  assign dsh      = DSH_W'(width) << BIT;
  assign bsh      = DIM_W'(band_h) << BB;
  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt = up_data;
    if ({1'b0, up_data.rem255} >= dsh) begin
      data_nxt.rem255    = REM_W'({1'b0, up_data.rem255} - dsh);
      data_nxt.q255[BIT] = 1'b1;
    end
    if ({1'b0, up_data.rem119} >= dsh) begin
      data_nxt.rem119    = REM_W'({1'b0, up_data.rem119} - dsh);
      data_nxt.q119[BIT] = 1'b1;
    end
    if (BIT < BAND_BITS) begin
      if ({1'b0, up_data.brem} >= bsh) begin
        data_nxt.brem     = ROW_W'({1'b0, up_data.brem} - bsh);
        data_nxt.band[BB] = 1'b1;
      end
    end
  end

  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- rtl/core/display_test_pattern_generator_top.sv -----
// ----------------------------------------------------------------------------
// display_test_pattern_generator_top
// Turns a pixel coordinate into the packed pixel of the selected test pattern.
// ----------------------------------------------------------------------------
// Takes one coordinate item per clock while the output does not stall and
// returns its pixel through one entry register, a chain of eight divider
// cells that each resolve one bit of the horizontal ramp quotient (the low
// three also resolve the band index), and one output register that packs the
// colour. Every stage has its own valid bit, so stalls on the output only hold
// items that cannot move and empty stages keep filling. Registers are meant to
// be written while no item is in flight.
// ----------------------------------------------------------------------------
module display_test_pattern_generator_top import dtpg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  dtpg_in_if.sink    in_item,
  dtpg_out_if.source out_item,
  dtpg_cfg_if.sink   cfg_wr
);

  localparam int NSTG = RAMP_BITS + 1;

  dtpg_cfg_t            cfg;
  logic [DIM_W-1:0]     w, h;
  logic [BAND_H_W-1:0]  band_h;
  logic                 in_frame, bars_ok, cov;
  dtpg_pipe_t           entry_nxt;

  logic                 c_valid [NSTG];
  logic                 c_ready [NSTG];
  dtpg_pipe_t           c_data  [NSTG];

  logic                 entry_valid_r, entry_valid_nxt;
  dtpg_pipe_t           entry_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]     out_pixel_r, out_pixel_nxt;
  logic                 out_cov_r, out_cov_nxt;
  logic                 out_load;
  logic [PIX_W-1:0]     bar_base, rgb;
  dtpg_pipe_t           last;

  dtpg_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  // entry stage
  assign w      = (cfg.width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.width;
  assign h      = (cfg.height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.height;
  assign band_h = h[DIM_W-1:BAND_BITS];

  assign in_frame = (w != '0) && ({1'b0, in_item.column} < w) && ({1'b0, in_item.row} < h);
  assign bars_ok  = (band_h != '0) && ({1'b0, in_item.row} < {band_h, {BAND_BITS{1'b0}}});

  always_comb begin
    unique case (cfg.mode)
      MODE_BARS:  cov = in_frame && bars_ok;
      MODE_GREY:  cov = in_frame;
      MODE_SOLID: cov = in_frame;
      default:    cov = 1'b0;
    endcase
  end

  always_comb begin
    entry_nxt.mode   = cfg.mode;
    entry_nxt.cov    = cov;
    entry_nxt.row    = in_item.row;
    entry_nxt.brem   = in_item.row;
    entry_nxt.band   = '0;
    entry_nxt.rem255 = (REM_W'(in_item.column) << RAMP_BITS) - REM_W'(in_item.column);
    entry_nxt.rem119 = (REM_W'(in_item.column) << 7) - (REM_W'(in_item.column) << 3)
                       - REM_W'(in_item.column);
    entry_nxt.q255   = '0;
    entry_nxt.q119   = '0;
  end

  assign in_item.ready   = !entry_valid_r || c_ready[0];
  assign entry_valid_nxt = in_item.ready ? in_item.valid : entry_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= 1'b0;
    end else begin
      entry_valid_r <= entry_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      entry_r <= entry_nxt;
    end
  end

  assign c_valid[0] = entry_valid_r;
  assign c_data[0]  = entry_r;

  // divider cell chain, quotient msb first
  for (genvar i = 0; i < RAMP_BITS; i++) begin : g_cell
    dtpg_div_cell #(
      .BIT (RAMP_BITS - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_valid[i]),
      .up_ready (c_ready[i]),
      .up_data  (c_data[i]),
      .dn_valid (c_valid[i+1]),
      .dn_ready (c_ready[i+1]),
      .dn_data  (c_data[i+1]),
      .width    (w),
      .band_h   (band_h)
    );
  end

  // output stage
  assign last     = c_data[NSTG-1];
  assign bar_base = band_color(last.band);

  always_comb begin
    unique case (last.mode)
      MODE_BARS:  rgb = {ramp_chan(bar_base[23:16], last.q255, last.q119),
                         ramp_chan(bar_base[15:8], last.q255, last.q119),
                         ramp_chan(bar_base[7:0], last.q255, last.q119)};
      MODE_GREY:  rgb = {last.row[7:0], last.row[7:0], last.row[7:0]};
      MODE_SOLID: rgb = cfg.solid;
      default:    rgb = '0;
    endcase
  end

  always_comb begin
    out_pixel_nxt = pack_color(cfg.fmt, rgb);
    if (last.mode == MODE_BARS && cfg.fmt == FMT_RGB565) begin
      out_pixel_nxt = out_pixel_nxt & RGB565_MASK;
    end
    if (!last.cov) begin
      out_pixel_nxt = '0;
    end
    out_cov_nxt = last.cov;
  end

  assign c_ready[NSTG-1] = !out_valid_r || out_item.ready;
  assign out_load        = c_valid[NSTG-1] && c_ready[NSTG-1];
  assign out_valid_nxt   = c_ready[NSTG-1] ? c_valid[NSTG-1] : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel_r <= out_pixel_nxt;
      out_cov_r   <= out_cov_nxt;
    end
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.pixel_value = out_pixel_r;
  assign out_item.covered     = out_cov_r;

endmodule

// ----- rtl/core/dtpg_checker.sv -----
// ----------------------------------------------------------------------------
// dtpg_checker
// Port-level checks of the test pattern generator, bound to the top level.
// ----------------------------------------------------------------------------
module dtpg_checker import dtpg_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] out_pixel_value,
  input logic             out_covered
);

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("item on output right after reset");

  // a stalled item keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_value) && $stable(out_covered))
    else $error("stalled output item changed");

  // uncovered pixels are black
  a_uncovered_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_covered |-> out_pixel_value == '0)
    else $error("uncovered pixel with nonzero value");

  // a draining output never blocks the input side
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // input valid must be known once out of reset
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid == 1'b1 || in_valid == 1'b0)
    else $error("input valid unknown");

endmodule

bind display_test_pattern_generator_top dtpg_checker u_dtpg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_item.valid),
  .in_ready        (in_item.ready),
  .out_valid       (out_item.valid),
  .out_ready       (out_item.ready),
  .out_pixel_value (out_item.pixel_value),
  .out_covered     (out_item.covered)
);
